@@ hw/rtl/substring_replace_stream_macros.svh @@
// Assertion macros for the substring replace stream checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SUBSTRING_REPLACE_STREAM_MACROS_SVH
`define SUBSTRING_REPLACE_STREAM_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define SRS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SRS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/srs_pkg.sv @@
// Shared sizes, types and helpers for the substring replace stream.
// No dependencies; imported by srs_cfg, srs_front, srs_back and the top level.
package srs_pkg;

  localparam int MAX_PATTERN     = 16;
  localparam int MAX_REPLACEMENT = 16;

  localparam int WORD_W    = 64;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 3;

  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int REP_N  = (MAX_REPLACEMENT > 0) ? MAX_REPLACEMENT : 1;
  localparam int RLEN_W = (MAX_REPLACEMENT > 0) ? $clog2(MAX_REPLACEMENT + 1) : 1;
  localparam int RIDX_W = (REP_N > 1) ? $clog2(REP_N) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO  = 3'd0,
    REG_PAT_HI  = 3'd1,
    REG_PAT_LEN = 3'd2,
    REG_REP_LO  = 3'd3,
    REG_REP_HI  = 3'd4,
    REG_REP_LEN = 3'd5
  } cfg_reg_t;

  // One queued text request
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } item_t;

  // Decoded configuration handed to the back end
  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] pat;
    logic [CNT_W-1:0]            plen;
    logic [REP_N-1:0][7:0]       rep;
    logic [RLEN_W-1:0]           rlen;
    logic                        clear_window;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_REPL,
    ST_FLUSH
  } back_state_t;

  // Pick byte i of a two-word string; positions 16 and up read zero
  function automatic logic [7:0] byte_of(logic [WORD_W-1:0] lo,
                                         logic [WORD_W-1:0] hi, int i);
    logic [7:0] b;
    b = 8'd0;
    if (i < 8) begin
      b = lo[8*i +: 8];
    end else if (i < 16) begin
      b = hi[8*(i-8) +: 8];
    end
    return b;
  endfunction

endpackage

@@ hw/rtl/srs_cfg.sv @@
// Configuration registers of the substring replace stream.
// Depends on srs_pkg; feeds decoded pattern and replacement to srs_back.
module srs_cfg import srs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  localparam int PSAT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int RSAT_W = (RLEN_W > LEN_W) ? RLEN_W : LEN_W;

  logic [WORD_W-1:0] pat_lo;
  logic [WORD_W-1:0] pat_hi;
  logic [LEN_W-1:0]  pat_len;
  logic [WORD_W-1:0] rep_lo;
  logic [WORD_W-1:0] rep_hi;
  logic [LEN_W-1:0]  rep_len;
  logic              wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Store register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo  <= '0;
      pat_hi  <= '0;
      pat_len <= '0;
      rep_lo  <= '0;
      rep_hi  <= '0;
      rep_len <= '0;
    end else if (wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LO:  pat_lo  <= cfg_data;
        REG_PAT_HI:  pat_hi  <= cfg_data;
        REG_PAT_LEN: pat_len <= cfg_data[LEN_W-1:0];
        REG_REP_LO:  rep_lo  <= cfg_data;
        REG_REP_HI:  rep_hi  <= cfg_data;
        REG_REP_LEN: rep_len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack bytes, saturate lengths and drop the window on a pattern rewrite
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cfg.pat[i] = byte_of(pat_lo, pat_hi, i);
    end
    for (int i = 0; i < REP_N; i++) begin
      cfg.rep[i] = byte_of(rep_lo, rep_hi, i);
    end
    cfg.plen = (PSAT_W'(pat_len) > PSAT_W'(MAX_PATTERN)) ?
               CNT_W'(MAX_PATTERN) : CNT_W'(pat_len);
    cfg.rlen = (RSAT_W'(rep_len) > RSAT_W'(MAX_REPLACEMENT)) ?
               RLEN_W'(MAX_REPLACEMENT) : RLEN_W'(rep_len);
    cfg.clear_window = 1'b0;
    if (wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_PAT_LO, REG_PAT_HI, REG_PAT_LEN: cfg.clear_window = 1'b1;
        default: cfg.clear_window = 1'b0;
      endcase
    end
  end

endmodule

@@ hw/rtl/srs_front.sv @@
// Front end: accepts text requests into a short queue for the back end.
// Depends on srs_pkg.
module srs_front import srs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head;
  logic [QPTR_W-1:0]   tail;
  logic [QCNT_W-1:0]   fill;
  logic                push;

  assign text_stall = (fill == QCNT_W'(QUEUE_DEPTH));
  assign push       = text_valid && !text_stall;
  assign q_valid    = (fill != '0);
  assign q_item     = mem[head];

  // Write the accepted request at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= '{text_byte: text_byte, end_of_text: end_of_text};
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        tail <= tail + QPTR_W'(1);
      end
      if (q_pop) begin
        head <= head + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (!push && q_pop) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/srs_back.sv @@
// Back end: window match, replacement sequencing, flush and output register.
// Depends on srs_pkg; fed by srs_front and srs_cfg.
module srs_back import srs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       byte_present,
  output logic       last_of_text
);

  logic [MAX_PATTERN-1:0][7:0] win;
  logic [MAX_PATTERN-1:0][7:0] win_next;
  logic [MAX_PATTERN-1:0][7:0] win_shift;
  logic [MAX_PATTERN-1:0][7:0] wn;
  logic [MAX_PATTERN-1:0][7:0] ws;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  back_state_t                 state;
  back_state_t                 state_next;
  logic [RIDX_W-1:0]           rep_idx;
  logic [RIDX_W-1:0]           rep_idx_next;
  logic                        rep_end;
  logic                        rep_end_next;

  logic       adv;
  logic       win_prefix;
  logic [7:0] pat_at_count;
  logic       do_slide;
  logic       do_take;
  logic       t_copy;
  logic       t_hit;
  logic       t_match;
  logic       t_grow;
  logic       rep_more;
  logic       rep_done;
  logic       emit;
  logic [7:0] emit_byte;
  logic       emit_present;
  logic       emit_last;

  assign adv = !result_valid || !result_stall;

  // Check the held window against the pattern start
  always_comb begin
    win_prefix = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CNT_W'(i) < count) && (win[i] != cfg.pat[i])) begin
        win_prefix = 1'b0;
      end
    end
  end

  // Build the appended window and the one-place shifts
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wn[i] = (CNT_W'(i) == count) ? q_item.text_byte : win[i];
    end
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      ws[i]        = wn[i+1];
      win_shift[i] = win[i+1];
    end
    ws[MAX_PATTERN-1]        = wn[MAX_PATTERN-1];
    win_shift[MAX_PATTERN-1] = win[MAX_PATTERN-1];
  end

  // Classify the head request against the window
  assign pat_at_count = cfg.pat[count[IDX_W-1:0]];
  assign do_slide = adv && (state == ST_RUN) && !win_prefix;
  assign do_take  = adv && (state == ST_RUN) && win_prefix && q_valid;
  assign t_copy   = (cfg.plen == '0);
  assign t_hit    = !t_copy && (q_item.text_byte == pat_at_count);
  assign t_match  = t_hit && ((count + CNT_W'(1)) == cfg.plen);
  assign t_grow   = t_hit && !t_match && !q_item.end_of_text;
  assign rep_more = (cfg.rlen > RLEN_W'(1));
  assign rep_done = ((RLEN_W'(rep_idx) + RLEN_W'(1)) == cfg.rlen);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (do_take && t_match && rep_more) begin
          state_next = ST_REPL;
        end else if (do_take && !t_copy && !t_match && !t_grow &&
                     q_item.end_of_text && (count != '0)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_REPL: begin
        if (adv && rep_done) begin
          state_next = ST_RUN;
        end
      end
      ST_FLUSH: begin
        if (adv && (count == CNT_W'(1))) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Outputs and window update
  always_comb begin
    emit         = 1'b0;
    emit_byte    = 8'd0;
    emit_present = 1'b1;
    emit_last    = 1'b0;
    q_pop        = 1'b0;
    win_next     = win;
    count_next   = count;
    rep_idx_next = rep_idx;
    rep_end_next = rep_end;
    unique case (state)
      ST_RUN: begin
        if (do_slide) begin
          // release the oldest byte of a window that broke the prefix
          emit       = 1'b1;
          emit_byte  = win[0];
          win_next   = win_shift;
          count_next = count - CNT_W'(1);
        end else if (do_take) begin
          q_pop = 1'b1;
          if (t_copy) begin
            emit      = 1'b1;
            emit_byte = q_item.text_byte;
            emit_last = q_item.end_of_text;
          end else if (t_match) begin
            count_next   = '0;
            rep_idx_next = RIDX_W'(1);
            rep_end_next = q_item.end_of_text;
            if (cfg.rlen != '0) begin
              emit      = 1'b1;
              emit_byte = cfg.rep[0];
              emit_last = q_item.end_of_text && !rep_more;
            end else if (q_item.end_of_text) begin
              // bare end marker after a deleted match
              emit         = 1'b1;
              emit_present = 1'b0;
              emit_last    = 1'b1;
            end
          end else if (t_grow) begin
            win_next   = wn;
            count_next = count + CNT_W'(1);
          end else begin
            // mismatch or end of text: release the oldest byte now
            emit      = 1'b1;
            emit_byte = wn[0];
            emit_last = q_item.end_of_text && (count == '0);
            win_next  = ws;
          end
        end
      end
      ST_REPL: begin
        if (adv) begin
          emit         = 1'b1;
          emit_byte    = cfg.rep[rep_idx];
          emit_last    = rep_end && rep_done;
          rep_idx_next = rep_idx + RIDX_W'(1);
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          emit       = 1'b1;
          emit_byte  = win[0];
          emit_last  = (count == CNT_W'(1));
          win_next   = win_shift;
          count_next = count - CNT_W'(1);
        end
      end
      default: ;
    endcase
    if (cfg.clear_window) begin
      count_next = '0;
    end
  end

  // Hold the window bytes
  always_ff @(posedge clk) begin
    win <= win_next;
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      count   <= '0;
      rep_idx <= '0;
      rep_end <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rep_idx <= rep_idx_next;
      rep_end <= rep_end_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte     <= emit_byte;
      byte_present <= emit_present;
      last_of_text <= emit_last;
    end
  end

endmodule

@@ hw/rtl/substring_replace_stream.sv @@
// Top level of the streaming find-and-replace block.
// Depends on srs_pkg, srs_cfg, srs_front and srs_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  text     | text_valid / text_stall | text_byte, end_of_text
//  result   | result_valid /          | out_byte, byte_present, last_of_text
//           |   result_stall          |
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// In the back end a text byte that emits at most one result is taken as it emits.
// A match emits its replacement bytes in turn (none for an empty replacement); a
// broken partial match releases its held bytes in turn, and an end of text flushes
// the pending bytes. An accepted request enters the four-entry request queue; the
// back end takes it from the queue head and loads the result register from it.
// Reset is synchronous; it clears queue pointers, window count, state and result
// valid. result_stall on a valid result freezes the back end; the queue keeps
// taking text meanwhile until it is full.
module substring_replace_stream import srs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_text,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [7:0]           out_byte,
  output logic                 byte_present,
  output logic                 last_of_text,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  srs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  srs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .last_of_text (last_of_text)
  );

endmodule

@@ hw/rtl/srs_checker.sv @@
// Port-level checks for substring_replace_stream, bound to the top level.
// Depends on substring_replace_stream_macros.svh.
`include "substring_replace_stream_macros.svh"

module srs_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [7:0] out_byte,
  input logic       byte_present,
  input logic       last_of_text
);

  // Hold a stalled result
  `SRS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid, "result dropped while stalled")

  `SRS_ASSERT_NEXT(a_payload_hold, clk, rst, result_valid && result_stall, $stable(out_byte) && $stable(byte_present) && $stable(last_of_text), "result payload changed while stalled")

  // A bare marker only ends a text and carries a zero byte
  `SRS_ASSERT_NOW(a_bare_marker, clk, rst, result_valid && !byte_present, last_of_text && (out_byte == 8'd0), "bare marker not final or not zero")

  // Nothing leaves the block right after reset
  `SRS_ASSERT_NOW(a_reset_quiet, clk, 1'b0, $past(rst) && !rst, !result_valid, "result valid right after reset")

endmodule

bind substring_replace_stream srs_checker u_srs_checker (.*);
